// ----- hw/rtl/oaht_pkg.sv -----
// Package: shared types and constants for the open-address hash table
`timescale 1ns / 1ps
package oaht_pkg;

    localparam int TABLE_SIZE_DEF = 11;
    localparam int KEY_W          = 32;
    localparam int MARK_W         = 2;
    localparam int SLOT_OUT_W     = 4;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_REDUCE,
        S_FIX,
        S_PROBE,
        S_FINISH
    } t_state;

endpackage

// ----- hw/rtl/oaht_if.sv -----
// Interfaces: request and response channels of the hash table
`timescale 1ns / 1ps
interface oaht_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          mode;
    logic signed [oaht_pkg::KEY_W-1:0]   key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

interface oaht_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           status;
    logic [oaht_pkg::SLOT_OUT_W-1:0]      slot_index;

    modport source (output valid, output status, output slot_index, input ready);
    modport sink   (input valid, input status, input slot_index, output ready);
endinterface

// ----- hw/rtl/oaht_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module oaht_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = oaht_pkg::TABLE_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ----- hw/rtl/open_address_hash_table.sv -----
// Unknown mode goes from idle straight to finish; other modes pass hash, reduce, fix and probe.
// Home slot: reciprocal multiply, product fold and sign fix on one shared multiplier, in hash, reduce and fix.
// Probing: one slot per cycle through the registered RAM read port, up to TABLE_SIZE.
// One operation at a time; ready only in idle, which is entered again once the finish state
// has loaded the result beat; the finish state waits while an earlier result beat is stalled.
// Reset: synchronous active low; then a clearing pass over all TABLE_SIZE slots empties every mark.
`timescale 1ns / 1ps
module open_address_hash_table #(
    parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    oaht_req_if.sink   i_req,
    oaht_rsp_if.source o_rsp
);

    localparam int SW     = $clog2(TABLE_SIZE);
    localparam int RAM_W  = oaht_pkg::MARK_W + oaht_pkg::KEY_W;
    localparam int unsigned WRAP_C = 32'(64'h1_0000_0000 % 64'(TABLE_SIZE));
    localparam logic [SW:0]   SIZE_X   = (SW+1)'(TABLE_SIZE);
    localparam logic [SW:0]   WRAP_MOD = WRAP_C[SW:0];
    localparam logic [SW-1:0] LAST     = SW'(TABLE_SIZE - 1);
    localparam logic [oaht_pkg::KEY_W-1:0] RECIP  = 32'(64'h1_0000_0000 / 64'(TABLE_SIZE));
    localparam logic [oaht_pkg::KEY_W-1:0] SIZE_W = 32'(TABLE_SIZE);

    oaht_pkg::t_state r_state, n_state;

    logic [1:0]                        r_mode, n_mode;
    logic [oaht_pkg::KEY_W-1:0]        r_key, n_key;
    logic [oaht_pkg::KEY_W-1:0]        r_quot, n_quot;
    logic [SW:0]                       r_rem, n_rem;
    logic [SW-1:0]                     r_pos, n_pos;
    logic [SW-1:0]                     r_cnt, n_cnt;
    logic                              r_have, n_have;
    logic [SW-1:0]                     r_tomb, n_tomb;
    logic [1:0]                        r_status, n_status;
    logic [SW-1:0]                     r_where, n_where;
    logic                              r_out_valid, n_out_valid;
    logic [1:0]                        r_out_status, n_out_status;
    logic [oaht_pkg::SLOT_OUT_W-1:0]   r_out_slot, n_out_slot;

    logic                  wr_en;
    logic [SW-1:0]         wr_addr;
    logic [RAM_W-1:0]      wr_data;
    logic [SW-1:0]         rd_addr;
    logic [RAM_W-1:0]      rd_data;

    logic [oaht_pkg::KEY_W-1:0]   mul_a;
    logic [oaht_pkg::KEY_W-1:0]   mul_b;
    logic [2*oaht_pkg::KEY_W-1:0] mul_p;

    logic [oaht_pkg::MARK_W-1:0] mark;
    logic [oaht_pkg::KEY_W-1:0]  slot_key;
    logic                        match;
    logic                        last;
    logic [SW:0]                 pos_inc;
    logic [SW-1:0]               pos_next;
    logic [SW:0]                 rem_x;
    logic [SW:0]                 home_x;
    logic [SW-1:0]               tomb_now;
    logic                        have_now;
    logic                        out_take;

    oaht_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign mul_p    = 64'(mul_a) * 64'(mul_b);
    assign mark     = rd_data[RAM_W-1 -: oaht_pkg::MARK_W];
    assign slot_key = rd_data[oaht_pkg::KEY_W-1:0];
    assign match    = (mark == oaht_pkg::MARK_USED) && (slot_key == r_key);
    assign last     = (r_cnt == LAST);
    assign pos_inc  = {1'b0, r_pos} + (SW+1)'(1);
    assign pos_next = (pos_inc == SIZE_X) ? '0 : pos_inc[SW-1:0];
    assign rem_x    = (r_rem >= SIZE_X) ? r_rem - SIZE_X : r_rem;
    assign tomb_now = r_have ? r_tomb : r_pos;
    assign have_now = r_have || (mark == oaht_pkg::MARK_TOMB);
    assign out_take = r_out_valid && o_rsp.ready;

    always_comb begin
        if (!r_key[oaht_pkg::KEY_W-1]) begin
            home_x = rem_x;
        end else if (rem_x >= WRAP_MOD) begin
            home_x = rem_x - WRAP_MOD;
        end else begin
            home_x = rem_x + SIZE_X - WRAP_MOD;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_key        = r_key;
        n_quot       = r_quot;
        n_rem        = r_rem;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_have       = r_have;
        n_tomb       = r_tomb;
        n_status     = r_status;
        n_where      = r_where;
        n_out_valid  = out_take ? 1'b0 : r_out_valid;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        wr_en        = 1'b0;
        wr_addr      = r_pos;
        wr_data      = '0;
        rd_addr      = r_pos;
        mul_a        = r_key;
        mul_b        = RECIP;

        case (r_state)
            oaht_pkg::S_CLEAR: begin
                wr_en = 1'b1;
                n_pos = pos_next;
                if (r_pos == LAST) begin
                    n_state = oaht_pkg::S_IDLE;
                end
            end
            oaht_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_mode  = i_req.mode;
                    n_key   = i_req.key;
                    n_rem   = '0;
                    n_where = '0;
                    if (i_req.mode == oaht_pkg::MODE_INSERT ||
                        i_req.mode == oaht_pkg::MODE_SEARCH ||
                        i_req.mode == oaht_pkg::MODE_DELETE) begin
                        n_state = oaht_pkg::S_HASH;
                    end else begin
                        n_status = oaht_pkg::STATUS_MISS;
                        n_state  = oaht_pkg::S_FINISH;
                    end
                end
            end
            oaht_pkg::S_HASH: begin
                n_quot  = mul_p[2*oaht_pkg::KEY_W-1:oaht_pkg::KEY_W];
                n_state = oaht_pkg::S_REDUCE;
            end
            oaht_pkg::S_REDUCE: begin
                mul_a   = r_quot;
                mul_b   = SIZE_W;
                n_rem   = r_key[SW:0] - mul_p[SW:0];
                n_state = oaht_pkg::S_FIX;
            end
            oaht_pkg::S_FIX: begin
                rd_addr = home_x[SW-1:0];
                n_pos   = home_x[SW-1:0];
                n_cnt   = '0;
                n_have  = 1'b0;
                n_state = oaht_pkg::S_PROBE;
            end
            oaht_pkg::S_PROBE: begin
                rd_addr = pos_next;
                n_pos   = pos_next;
                n_cnt   = r_cnt + SW'(1);
                if (mark == oaht_pkg::MARK_TOMB && !r_have) begin
                    n_have = 1'b1;
                    n_tomb = r_pos;
                end
                if (r_mode == oaht_pkg::MODE_INSERT) begin
                    if (match) begin
                        n_status = oaht_pkg::STATUS_OK;
                        n_where  = r_pos;
                        n_state  = oaht_pkg::S_FINISH;
                    end else if (mark == oaht_pkg::MARK_EMPTY) begin
                        wr_en    = 1'b1;
                        wr_addr  = tomb_now;
                        wr_data  = {oaht_pkg::MARK_USED, r_key};
                        n_status = oaht_pkg::STATUS_OK;
                        n_where  = tomb_now;
                        n_state  = oaht_pkg::S_FINISH;
                    end else if (last) begin
                        if (have_now) begin
                            wr_en    = 1'b1;
                            wr_addr  = tomb_now;
                            wr_data  = {oaht_pkg::MARK_USED, r_key};
                            n_status = oaht_pkg::STATUS_OK;
                            n_where  = tomb_now;
                        end else begin
                            n_status = oaht_pkg::STATUS_FULL;
                        end
                        n_state = oaht_pkg::S_FINISH;
                    end
                end else begin
                    if (mark == oaht_pkg::MARK_EMPTY) begin
                        n_status = oaht_pkg::STATUS_MISS;
                        n_state  = oaht_pkg::S_FINISH;
                    end else if (match) begin
                        if (r_mode == oaht_pkg::MODE_DELETE) begin
                            wr_en   = 1'b1;
                            wr_addr = r_pos;
                            wr_data = {oaht_pkg::MARK_TOMB, r_key};
                        end
                        n_status = oaht_pkg::STATUS_OK;
                        n_where  = r_pos;
                        n_state  = oaht_pkg::S_FINISH;
                    end else if (last) begin
                        n_status = oaht_pkg::STATUS_MISS;
                        n_state  = oaht_pkg::S_FINISH;
                    end
                end
            end
            oaht_pkg::S_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_slot   = (r_status == oaht_pkg::STATUS_OK) ?
                                   oaht_pkg::SLOT_OUT_W'(r_where) : '0;
                    n_state      = oaht_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = oaht_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= oaht_pkg::S_CLEAR;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_quot       <= n_quot;
        r_rem        <= n_rem;
        r_cnt        <= n_cnt;
        r_have       <= n_have;
        r_tomb       <= n_tomb;
        r_status     <= n_status;
        r_where      <= n_where;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
    end

    assign i_req.ready      = (r_state == oaht_pkg::S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.slot_index = r_out_slot;

endmodule

// ----- hw/rtl/oaht_checker.sv -----
// Checker: port-level assertions for the hash table, bound to the top level
`timescale 1ns / 1ps
module oaht_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [1:0]                          i_out_status,
    input logic [oaht_pkg::SLOT_OUT_W-1:0]     i_out_slot
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("outputs not quiet after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready held high while an operation runs");

    a_slot_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != oaht_pkg::STATUS_OK |-> i_out_slot == '0)
        else $error("nonzero slot with a failing status");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_status) && $stable(i_out_slot))
        else $error("stalled response beat changed");

endmodule

bind open_address_hash_table oaht_checker u_oaht_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_status (o_rsp.status),
    .i_out_slot   (o_rsp.slot_index)
);

// ----- bench/tb_open_address_hash_table.sv -----
// Testbench: directed and random insert/search/delete traffic checked against a hash set model
`timescale 1ns / 1ps
module tb_open_address_hash_table;

    localparam int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF;
    localparam int N_RANDOM   = 1025;
    localparam int KEY_POOL   = 24;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]                      status;
        logic [oaht_pkg::SLOT_OUT_W-1:0] slot;
    } t_probe_outcome;

    class t_hash_set_scoreboard;
        logic [oaht_pkg::KEY_W-1:0]  slot_keys [TABLE_SIZE];
        logic [oaht_pkg::MARK_W-1:0] slot_marks[TABLE_SIZE];
        t_probe_outcome    outcome_q[$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       status_seen[4];
        int unsigned       mode_seen[4];

        function new();
            foreach (slot_marks[i]) begin
                slot_marks[i] = oaht_pkg::MARK_EMPTY;
                slot_keys[i]  = '0;
            end
            foreach (status_seen[i]) begin
                status_seen[i] = 0;
                mode_seen[i]   = 0;
            end
            mismatches = 0;
            checked    = 0;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        function int home_slot(logic [oaht_pkg::KEY_W-1:0] key);
            longint v;
            v = longint'($signed(key)) % TABLE_SIZE;
            if (v < 0) v += TABLE_SIZE;
            return int'(v);
        endfunction

        function int next_slot(int pos);
            return (pos + 1 == TABLE_SIZE) ? 0 : pos + 1;
        endfunction

        function bit locate(logic [oaht_pkg::KEY_W-1:0] key, output int where);
            int pos;
            pos   = home_slot(key);
            where = 0;
            for (int n = 0; n < TABLE_SIZE; n++) begin
                if (slot_marks[pos] == oaht_pkg::MARK_EMPTY) return 1'b0;
                if (slot_marks[pos] == oaht_pkg::MARK_USED && slot_keys[pos] == key) begin
                    where = pos;
                    return 1'b1;
                end
                pos = next_slot(pos);
            end
            return 1'b0;
        endfunction

        function logic [1:0] insert_key(logic [oaht_pkg::KEY_W-1:0] key, output int where);
            int pos;
            int dst;
            bit have_tomb;
            int tomb;
            pos       = home_slot(key);
            have_tomb = 1'b0;
            tomb      = 0;
            where     = 0;
            for (int n = 0; n < TABLE_SIZE; n++) begin
                if (slot_marks[pos] == oaht_pkg::MARK_USED && slot_keys[pos] == key) begin
                    where = pos;
                    return oaht_pkg::STATUS_OK;
                end
                if (slot_marks[pos] == oaht_pkg::MARK_TOMB && !have_tomb) begin
                    have_tomb = 1'b1;
                    tomb      = pos;
                end
                if (slot_marks[pos] == oaht_pkg::MARK_EMPTY) begin
                    dst             = have_tomb ? tomb : pos;
                    slot_keys[dst]  = key;
                    slot_marks[dst] = oaht_pkg::MARK_USED;
                    where           = dst;
                    return oaht_pkg::STATUS_OK;
                end
                pos = next_slot(pos);
            end
            if (have_tomb) begin
                slot_keys[tomb]  = key;
                slot_marks[tomb] = oaht_pkg::MARK_USED;
                where            = tomb;
                return oaht_pkg::STATUS_OK;
            end
            return oaht_pkg::STATUS_FULL;
        endfunction

        function t_probe_outcome apply_op(logic [1:0] mode, logic [oaht_pkg::KEY_W-1:0] key);
            int             where;
            logic [1:0]     st;
            t_probe_outcome res;
            where = 0;
            case (mode)
                oaht_pkg::MODE_INSERT: st = insert_key(key, where);
                oaht_pkg::MODE_SEARCH: begin
                    st = locate(key, where) ? oaht_pkg::STATUS_OK : oaht_pkg::STATUS_MISS;
                end
                oaht_pkg::MODE_DELETE: begin
                    if (locate(key, where)) begin
                        slot_marks[where] = oaht_pkg::MARK_TOMB;
                        st = oaht_pkg::STATUS_OK;
                    end else begin
                        st = oaht_pkg::STATUS_MISS;
                    end
                end
                default: st = oaht_pkg::STATUS_MISS;
            endcase
            if (st != oaht_pkg::STATUS_OK) where = 0;
            res.status = st;
            res.slot   = where[oaht_pkg::SLOT_OUT_W-1:0];
            return res;
        endfunction

        function void note_request(logic [1:0] mode, logic [oaht_pkg::KEY_W-1:0] key);
            mode_seen[mode]++;
            outcome_q.push_back(apply_op(mode, key));
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        function void check_response(logic [1:0] status,
                                     logic [oaht_pkg::SLOT_OUT_W-1:0] slot);
            t_probe_outcome want;
            checked++;
            if (outcome_q.size() == 0) begin
                flag($sformatf("unexpected beat status=%0d slot=%0d", status, slot));
                return;
            end
            want = outcome_q.pop_front();
            status_seen[want.status]++;
            if (status !== want.status)
                flag($sformatf("status expected %0d actual %0d", want.status, status));
            if (slot !== want.slot)
                flag($sformatf("slot_index expected %0d actual %0d", want.slot, slot));
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    bit                         steady = 1'b0;
    logic [oaht_pkg::KEY_W-1:0] key_pool[KEY_POOL];
    t_hash_set_scoreboard       sb = new();

    oaht_req_if req_ch();
    oaht_rsp_if rsp_ch();

    open_address_hash_table dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    always #10 i_clk = ~i_clk;

    function automatic int unsigned draw_wait();
        return steady ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic send_beat(input logic [1:0] mode, input logic [oaht_pkg::KEY_W-1:0] key);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.key   <= key;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        sb.note_request(mode, key);
    endtask

    task automatic take_beat();
        int unsigned stall;
        stall = draw_wait();
        if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge i_clk);
        end
        rsp_ch.ready <= 1'b1;
        @(posedge i_clk);
        while (rsp_ch.valid !== 1'b1) @(posedge i_clk);
        sb.check_response(rsp_ch.status, rsp_ch.slot_index);
    endtask

    initial begin
        rsp_ch.ready <= 1'b0;
        forever take_beat();
    end

    initial begin
        logic [1:0]                 mode;
        logic [oaht_pkg::KEY_W-1:0] key;
        int unsigned                pick;

        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.mode  <= oaht_pkg::MODE_INSERT;
        req_ch.key   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_beat(oaht_pkg::MODE_SEARCH, 32'd5);
        send_beat(oaht_pkg::MODE_DELETE, 32'd5);
        send_beat(oaht_pkg::MODE_INSERT, 32'd0);
        send_beat(oaht_pkg::MODE_INSERT, 32'd11);
        send_beat(oaht_pkg::MODE_INSERT, 32'h8000_0000);
        send_beat(oaht_pkg::MODE_INSERT, 32'h7FFF_FFFF);
        send_beat(oaht_pkg::MODE_INSERT, 32'hFFFF_FFFF);
        send_beat(oaht_pkg::MODE_INSERT, 32'd10);
        send_beat(oaht_pkg::MODE_INSERT, 32'd0);
        send_beat(oaht_pkg::MODE_SEARCH, 32'd11);
        send_beat(MODE_UNUSED, 32'hFFFF_FFFF);
        send_beat(oaht_pkg::MODE_DELETE, 32'd0);
        send_beat(oaht_pkg::MODE_SEARCH, 32'd11);
        send_beat(oaht_pkg::MODE_INSERT, 32'd11);
        send_beat(oaht_pkg::MODE_INSERT, 32'd22);
        for (int k = 2; k <= 9; k++) send_beat(oaht_pkg::MODE_INSERT, oaht_pkg::KEY_W'(k));
        send_beat(oaht_pkg::MODE_INSERT, 32'd12345);
        send_beat(oaht_pkg::MODE_SEARCH, 32'd12345);

        for (int i = 0; i < KEY_POOL; i++) begin
            key = oaht_pkg::KEY_W'($urandom_range(0, 60)) - oaht_pkg::KEY_W'(30);
            key_pool[i] = (i < KEY_POOL / 2) ? oaht_pkg::KEY_W'($urandom) : key;
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            steady = (i >= 300 && i < 420) || (i >= 750 && i < 850);
            if (i == 500) begin
                req_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)      mode = oaht_pkg::MODE_INSERT;
            else if (pick < 70) mode = oaht_pkg::MODE_SEARCH;
            else if (pick < 95) mode = oaht_pkg::MODE_DELETE;
            else                mode = MODE_UNUSED;
            if ($urandom_range(0, 9) == 0) key = oaht_pkg::KEY_W'($urandom);
            else                           key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            send_beat(mode, key);
        end
        steady = 1'b0;

        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2 * TABLE_SIZE + 40) @(posedge i_clk);

        $display("requests: %0d insert, %0d search, %0d delete, %0d unknown mode",
                 sb.mode_seen[oaht_pkg::MODE_INSERT], sb.mode_seen[oaht_pkg::MODE_SEARCH],
                 sb.mode_seen[oaht_pkg::MODE_DELETE], sb.mode_seen[MODE_UNUSED]);
        $display("results checked: %0d (%0d ok, %0d miss, %0d full), mismatches: %0d",
                 sb.checked, sb.status_seen[oaht_pkg::STATUS_OK],
                 sb.status_seen[oaht_pkg::STATUS_MISS],
                 sb.status_seen[oaht_pkg::STATUS_FULL], sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("open_address_hash_table regression: pass");
        end else begin
            $display("open_address_hash_table regression: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout waiting for handshakes");
        $display("open_address_hash_table regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/oaht_pkg.sv
hw/rtl/oaht_if.sv
hw/rtl/oaht_ram.sv
hw/rtl/open_address_hash_table.sv
hw/rtl/oaht_checker.sv
bench/tb_open_address_hash_table.sv
